// ===== rtl/dpd_pkg.sv =====
// Shared types and constants for the drive PID block with gyro drift correction.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package dpd_pkg;

    localparam int ENC_W    = 24;
    localparam int GYRO_W   = 16;
    localparam int TGT_W    = 16;
    localparam int GAIN_W   = 8;
    localparam int ERR_W    = 26;
    localparam int DIFF_W   = 27;
    localparam int INT_W    = 9;
    localparam int SETTLE_W = 17;
    localparam int PP_W     = ERR_W + GAIN_W + 1;
    localparam int PD_W     = DIFF_W + GAIN_W + 1;
    localparam int PI_W     = INT_W + GAIN_W + 1;
    localparam int DRIFT_W  = GYRO_W + GAIN_W + 1;
    localparam int SUM_W    = PD_W + 2;
    localparam int MOTOR_W  = 8;
    localparam int POW_W    = 8;

    localparam int TICK_MS        = 20;
    localparam int INTEGRAL_LIMIT = 200;
    localparam int INTEGRAL_ZONE  = 210;
    localparam int UNLOCK_ERROR   = 100;
    localparam int MIN_WAIT_MS    = 250;
    localparam int DRIVE_SCALE    = 70;
    localparam int STRAFE_SCALE   = 127;
    localparam int TURN_SCALE     = 10;
    localparam int MOTOR_LIMIT    = 127;

    // direction codes
    localparam logic [2:0] MODE_NORTH = 3'd0;
    localparam logic [2:0] MODE_SOUTH = 3'd1;
    localparam logic [2:0] MODE_LEFT  = 3'd2;
    localparam logic [2:0] MODE_RIGHT = 3'd3;
    localparam logic [2:0] MODE_EAST  = 3'd4;
    localparam logic [2:0] MODE_WEST  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_TARGET    = 3'd1;
    localparam logic [2:0] REG_WAIT      = 3'd2;
    localparam logic [2:0] REG_MAX_POWER = 3'd3;
    localparam logic [2:0] REG_GAIN_P    = 3'd4;
    localparam logic [2:0] REG_GAIN_I    = 3'd5;
    localparam logic [2:0] REG_GAIN_D    = 3'd6;
    localparam logic [2:0] REG_GAIN_DR   = 3'd7;

    typedef struct packed {
        logic                     start_move;
        logic signed [ENC_W-1:0]  enc_front_left;
        logic signed [ENC_W-1:0]  enc_front_right;
        logic signed [ENC_W-1:0]  enc_back_left;
        logic signed [ENC_W-1:0]  enc_back_right;
        logic signed [GYRO_W-1:0] gyro_tenths;
    } t_in_item;

    typedef struct packed {
        logic signed [MOTOR_W-1:0] motor_front_left;
        logic signed [MOTOR_W-1:0] motor_front_right;
        logic signed [MOTOR_W-1:0] motor_back_left;
        logic signed [MOTOR_W-1:0] motor_back_right;
        logic                      move_done;
    } t_out_item;

    typedef struct packed {
        logic [2:0]              direction_mode;
        logic signed [TGT_W-1:0] target_sixteenths;
        logic [15:0]             wait_ms;
        logic [6:0]              max_power;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic [GAIN_W-1:0]       gain_drift;
    } t_cfg;

    // error stage -> gain stage
    typedef struct packed {
        logic                     valid;
        logic                     done;
        logic [2:0]               mode;
        logic signed [ERR_W-1:0]  err;
        logic signed [INT_W-1:0]  integ;
        logic signed [DIFF_W-1:0] diff;
        logic signed [GYRO_W-1:0] gyro;
    } t_trk;

    // gain stage -> mixer
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic [2:0]                mode;
        logic signed [PP_W-1:0]    prod_p;
        logic signed [PI_W-1:0]    prod_i;
        logic signed [PD_W-1:0]    prod_d;
        logic signed [DRIFT_W-1:0] drift;
    } t_prod;

endpackage

// ===== rtl/dpd_track.sv =====
// Error formation and PID/settle state update, one request per cycle while i_en is high.
// Depends on dpd_pkg; registers its result into a t_trk stage.
module dpd_track (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  dpd_pkg::t_in_item i_item,
    input  dpd_pkg::t_cfg    i_cfg,
    output dpd_pkg::t_trk    o_stage
);

    localparam int EW = dpd_pkg::ENC_W;
    localparam int RW = dpd_pkg::ERR_W;
    localparam int SW = dpd_pkg::SETTLE_W;
    localparam logic signed [RW-1:0] ZONE     = RW'(dpd_pkg::INTEGRAL_ZONE);
    localparam logic signed [RW-1:0] ILIM     = RW'(dpd_pkg::INTEGRAL_LIMIT);
    localparam logic signed [RW-1:0] UNLOCK   = RW'(dpd_pkg::UNLOCK_ERROR);
    localparam logic [SW-1:0]        SMAX     = {SW{1'b1}};
    localparam logic [SW-1:0]        MIN_WAIT = SW'(dpd_pkg::MIN_WAIT_MS);

    logic signed [dpd_pkg::INT_W-1:0]  r_integ, n_integ;
    logic signed [RW-1:0]              r_prev, n_prev;
    logic [SW-1:0]                     r_settle, n_settle;
    logic                              r_lock, n_lock;
    logic                              r_fin, n_fin;
    dpd_pkg::t_trk                     r_stage, n_stage;

    logic [EW-1:0]     a_fl, a_fr, a_bl, a_br;
    logic [EW+1:0]     pos_sum;
    logic [EW-1:0]     pos;
    logic signed [23:0] t70, t127, t70d, t127d;
    logic [16:0]       t_abs, g_abs, turn_t;
    logic [20:0]       t10;
    logic signed [RW-1:0] err, isum;
    logic signed [dpd_pkg::INT_W-1:0] integ0, integ;
    logic signed [RW-1:0] prev0;
    logic [SW-1:0]     settle0, wait_eff;
    logic [SW:0]       settle_inc;
    logic              lock0, fin0, in_zone, stop;
    logic signed [dpd_pkg::DIFF_W-1:0] diff;

    function automatic logic [EW-1:0] abs_enc(input logic signed [EW-1:0] v);
        return v[EW-1] ? (~v + EW'(1)) : v;
    endfunction

    always_comb begin
        a_fl = abs_enc(i_item.enc_front_left);
        a_fr = abs_enc(i_item.enc_front_right);
        a_bl = abs_enc(i_item.enc_back_left);
        a_br = abs_enc(i_item.enc_back_right);
        pos_sum = {2'b00, a_fl} + {2'b00, a_bl} + {2'b00, a_fr} + {2'b00, a_br};
        pos = pos_sum[EW+1:2];

        // target scaling with division truncated toward zero
        t70  = $signed({{8{i_cfg.target_sixteenths[15]}}, i_cfg.target_sixteenths})
               * 24'(dpd_pkg::DRIVE_SCALE);
        t127 = $signed({{8{i_cfg.target_sixteenths[15]}}, i_cfg.target_sixteenths})
               * 24'(dpd_pkg::STRAFE_SCALE);
        t70d  = t70[23]  ? ((t70 + 24'sd15) >>> 4)  : (t70 >>> 4);
        t127d = t127[23] ? ((t127 + 24'sd15) >>> 4) : (t127 >>> 4);

        t_abs = i_cfg.target_sixteenths[15] ?
                (17'd0 - {1'b1, i_cfg.target_sixteenths}) : {1'b0, i_cfg.target_sixteenths};
        g_abs = i_item.gyro_tenths[15] ?
                (17'd0 - {1'b1, i_item.gyro_tenths}) : {1'b0, i_item.gyro_tenths};
        t10    = {4'd0, t_abs} * 21'(dpd_pkg::TURN_SCALE);
        turn_t = t10[20:4];

        case (i_cfg.direction_mode)
            dpd_pkg::MODE_NORTH, dpd_pkg::MODE_SOUTH:
                err = {{(RW-24){t70d[23]}}, t70d} - {2'b00, pos};
            dpd_pkg::MODE_LEFT, dpd_pkg::MODE_RIGHT:
                err = {{(RW-17){1'b0}}, turn_t} - {{(RW-17){1'b0}}, g_abs};
            default:
                err = {{(RW-24){t127d[23]}}, t127d} - {2'b00, pos};
        endcase

        // start of move clears state; the timer advances by TICK_MS on every live tick until the move finishes
        settle_inc = {1'b0, r_settle} + (SW+1)'(dpd_pkg::TICK_MS);
        if (i_item.start_move) begin
            integ0  = '0;
            prev0   = '0;
            settle0 = '0;
            lock0   = 1'b1;
            fin0    = 1'b0;
        end else begin
            integ0  = r_integ;
            prev0   = r_prev;
            settle0 = r_fin ? r_settle : (settle_inc[SW] ? SMAX : settle_inc[SW-1:0]);
            lock0   = r_lock;
            fin0    = r_fin;
        end

        in_zone = (err != '0) && (err < ZONE) && (err > -ZONE);
        isum = {{(RW-dpd_pkg::INT_W){integ0[dpd_pkg::INT_W-1]}}, integ0} + err;
        if (!in_zone)
            integ = '0;
        else if (isum > ILIM)
            integ = dpd_pkg::INT_W'(ILIM);
        else if (isum < -ILIM)
            integ = dpd_pkg::INT_W'(-ILIM);
        else
            integ = isum[dpd_pkg::INT_W-1:0];

        diff = (err == '0) ? '0 : ({err[RW-1], err} - {prev0[RW-1], prev0});

        wait_eff = ({1'b0, i_cfg.wait_ms} < MIN_WAIT) ? MIN_WAIT : {1'b0, i_cfg.wait_ms};

        n_integ  = r_integ;
        n_prev   = r_prev;
        n_settle = r_settle;
        n_lock   = r_lock;
        n_fin    = r_fin;
        stop     = 1'b0;
        if (fin0 || (i_cfg.direction_mode > dpd_pkg::MODE_WEST)) begin
            n_integ  = integ0;
            n_prev   = prev0;
            n_settle = settle0;
            n_lock   = lock0;
            n_fin    = 1'b1;
            stop     = 1'b1;
        end else begin
            n_integ  = integ;
            n_prev   = err;
            n_lock   = lock0 && !(err < UNLOCK);
            n_settle = n_lock ? '0 : settle0;
            stop     = (n_settle >= wait_eff);
            n_fin    = stop;
        end

        n_stage.valid = i_valid;
        n_stage.done  = stop;
        n_stage.mode  = i_cfg.direction_mode;
        n_stage.err   = err;
        n_stage.integ = integ;
        n_stage.diff  = diff;
        n_stage.gyro  = i_item.gyro_tenths;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ       <= '0;
            r_prev        <= '0;
            r_settle      <= '0;
            r_lock        <= 1'b1;
            r_fin         <= 1'b0;
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
            if (i_valid) begin
                r_integ  <= n_integ;
                r_prev   <= n_prev;
                r_settle <= n_settle;
                r_lock   <= n_lock;
                r_fin    <= n_fin;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/dpd_gain.sv =====
// Gain multipliers: P, I, D and gyro drift products, all in parallel, registered.
// Depends on dpd_pkg; consumes t_trk and produces t_prod.
module dpd_gain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  dpd_pkg::t_trk i_stage,
    input  dpd_pkg::t_cfg i_cfg,
    output dpd_pkg::t_prod o_stage
);

    dpd_pkg::t_prod r_stage, n_stage;
    logic signed [dpd_pkg::GAIN_W:0] gp, gi, gd, gdr;
    logic                            turning;

    always_comb begin
        gp  = $signed({1'b0, i_cfg.gain_p});
        gi  = $signed({1'b0, i_cfg.gain_i});
        gd  = $signed({1'b0, i_cfg.gain_d});
        gdr = $signed({1'b0, i_cfg.gain_drift});
        turning = (i_stage.mode == dpd_pkg::MODE_LEFT) || (i_stage.mode == dpd_pkg::MODE_RIGHT);

        n_stage.valid  = i_stage.valid;
        n_stage.done   = i_stage.done;
        n_stage.mode   = i_stage.mode;
        n_stage.prod_p = gp * i_stage.err;
        n_stage.prod_i = gi * i_stage.integ;
        n_stage.prod_d = gd * i_stage.diff;
        // kept as its own signed product so the gyro sign survives
        n_stage.drift  = gdr * i_stage.gyro;
        if (turning)
            n_stage.drift = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/dpd_mix.sv =====
// PID sum to clamped power, then per-wheel mixing with drift and output register.
// Depends on dpd_pkg; consumes t_prod, drives the result request.
module dpd_mix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  dpd_pkg::t_prod    i_stage,
    input  dpd_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output dpd_pkg::t_out_item o_item
);

    localparam int SW = dpd_pkg::SUM_W;
    localparam int DW = dpd_pkg::DRIFT_W;
    localparam int MW = DW + 1;
    localparam logic signed [MW-1:0] MLIM = MW'(dpd_pkg::MOTOR_LIMIT);

    logic signed [SW-1:0]               sum, quo, mp;
    logic signed [dpd_pkg::POW_W-1:0]   n_pow, r_pow;
    logic signed [DW-1:0]               r_drift;
    logic [2:0]                         r_mode;
    logic                               r_done, r_pvalid;
    logic signed [15:0]                 pw;
    logic signed [DW-1:0]               dr;
    logic                               r_out_valid;
    dpd_pkg::t_out_item                 r_out, n_out;

    function automatic logic signed [dpd_pkg::MOTOR_W-1:0] motor_cmd(
        input logic signed [15:0] p,
        input logic signed [DW-1:0] d
    );
        logic signed [MW-1:0] v, q;
        v = {{(MW-16){p[15]}}, p} + {d[DW-1], d};
        q = v[MW-1] ? ((v + MW'(255)) >>> 8) : (v >>> 8);
        if (q > MLIM)
            return dpd_pkg::MOTOR_W'(MLIM);
        else if (q < -MLIM)
            return dpd_pkg::MOTOR_W'(-MLIM);
        else
            return q[dpd_pkg::MOTOR_W-1:0];
    endfunction

    // power stage
    always_comb begin
        sum = {{(SW-dpd_pkg::PP_W){i_stage.prod_p[dpd_pkg::PP_W-1]}}, i_stage.prod_p}
            + {{(SW-dpd_pkg::PI_W){i_stage.prod_i[dpd_pkg::PI_W-1]}}, i_stage.prod_i}
            + {{(SW-dpd_pkg::PD_W){i_stage.prod_d[dpd_pkg::PD_W-1]}}, i_stage.prod_d};
        quo = sum[SW-1] ? ((sum + SW'(255)) >>> 8) : (sum >>> 8);
        mp  = {{(SW-7){1'b0}}, i_cfg.max_power};
        if (quo > mp)
            n_pow = dpd_pkg::POW_W'(mp);
        else if (quo < -mp)
            n_pow = dpd_pkg::POW_W'(-mp);
        else
            n_pow = quo[dpd_pkg::POW_W-1:0];
    end

    // wheel mixing
    always_comb begin
        pw = {r_pow, 8'd0};
        dr = r_drift;
        n_out.move_done = r_done;
        case (r_mode)
            dpd_pkg::MODE_NORTH: begin
                n_out.motor_front_left  = motor_cmd(pw, -dr);
                n_out.motor_front_right = motor_cmd(pw, dr);
                n_out.motor_back_left   = motor_cmd(pw, -dr);
                n_out.motor_back_right  = motor_cmd(pw, dr);
            end
            dpd_pkg::MODE_SOUTH: begin
                n_out.motor_front_left  = motor_cmd(-pw, -dr);
                n_out.motor_front_right = motor_cmd(-pw, dr);
                n_out.motor_back_left   = motor_cmd(-pw, -dr);
                n_out.motor_back_right  = motor_cmd(-pw, dr);
            end
            dpd_pkg::MODE_LEFT: begin
                n_out.motor_front_left  = motor_cmd(-pw, '0);
                n_out.motor_front_right = motor_cmd(pw, '0);
                n_out.motor_back_left   = motor_cmd(-pw, '0);
                n_out.motor_back_right  = motor_cmd(pw, '0);
            end
            dpd_pkg::MODE_RIGHT: begin
                n_out.motor_front_left  = motor_cmd(pw, '0);
                n_out.motor_front_right = motor_cmd(-pw, '0);
                n_out.motor_back_left   = motor_cmd(pw, '0);
                n_out.motor_back_right  = motor_cmd(-pw, '0);
            end
            dpd_pkg::MODE_EAST: begin
                n_out.motor_front_left  = motor_cmd(pw, -dr);
                n_out.motor_front_right = motor_cmd(-pw, dr);
                n_out.motor_back_left   = motor_cmd(-pw, -dr);
                n_out.motor_back_right  = motor_cmd(pw, dr);
            end
            default: begin
                n_out.motor_front_left  = motor_cmd(-pw, -dr);
                n_out.motor_front_right = motor_cmd(pw, dr);
                n_out.motor_back_left   = motor_cmd(pw, -dr);
                n_out.motor_back_right  = motor_cmd(-pw, dr);
            end
        endcase
        if (r_done) begin
            n_out.motor_front_left  = '0;
            n_out.motor_front_right = '0;
            n_out.motor_back_left   = '0;
            n_out.motor_back_right  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_pvalid    <= i_stage.valid;
            r_out_valid <= r_pvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow   <= n_pow;
            r_drift <= i_stage.drift;
            r_mode  <= i_stage.mode;
            r_done  <= i_stage.done;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== rtl/drive_pid_with_drift_correction.sv =====
// Top level of the drive PID block: configuration registers, input register and pipeline.
// Depends on dpd_pkg, dpd_track, dpd_gain and dpd_mix.
//
// One request in, one result out. The pipeline takes a new request every cycle unless the
// output register is stalled: the PID and settle state is updated in the error stage in
// the same cycle the request leaves the input register, so the following request sees it
// at once. Stages: input register, error/state, gain multipliers (four in
// parallel), power clamp, wheel mixing into the output register. The whole pipeline
// advances when the output register is empty or being taken, so o_in_ready follows
// i_out_ready combinationally. Configuration writes are accepted every cycle and must be
// issued only while no request is in flight.
module drive_pid_with_drift_correction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dpd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dpd_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    dpd_pkg::t_cfg     r_cfg;
    dpd_pkg::t_in_item r_in;
    logic              r_in_valid;
    logic              en;
    dpd_pkg::t_trk     trk;
    dpd_pkg::t_prod    prod;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction_mode    <= dpd_pkg::MODE_NORTH;
            r_cfg.target_sixteenths <= '0;
            r_cfg.wait_ms           <= 16'(dpd_pkg::MIN_WAIT_MS);
            r_cfg.max_power         <= 7'd127;
            r_cfg.gain_p            <= 8'd51;
            r_cfg.gain_i            <= 8'd26;
            r_cfg.gain_d            <= 8'd102;
            r_cfg.gain_drift        <= 8'd205;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dpd_pkg::REG_DIRECTION: r_cfg.direction_mode    <= i_cfg_data[2:0];
                dpd_pkg::REG_TARGET:    r_cfg.target_sixteenths <= i_cfg_data;
                dpd_pkg::REG_WAIT:      r_cfg.wait_ms           <= i_cfg_data;
                dpd_pkg::REG_MAX_POWER: r_cfg.max_power         <= i_cfg_data[6:0];
                dpd_pkg::REG_GAIN_P:    r_cfg.gain_p            <= i_cfg_data[7:0];
                dpd_pkg::REG_GAIN_I:    r_cfg.gain_i            <= i_cfg_data[7:0];
                dpd_pkg::REG_GAIN_D:    r_cfg.gain_d            <= i_cfg_data[7:0];
                dpd_pkg::REG_GAIN_DR:   r_cfg.gain_drift        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in_item;
        end
    end

    dpd_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_stage (trk)
    );

    dpd_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (trk),
        .i_cfg   (r_cfg),
        .o_stage (prod)
    );

    dpd_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (prod),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

// ===== verif/dpd_motor_checker.sv =====
// Scoreboard for drive_pid_with_drift_correction: watches the request, result and register
// channels, predicts the motor commands of every request and compares them in order.
// Depends on dpd_pkg only.
module dpd_motor_checker
    import dpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // register copy
    int cfg_mode, cfg_target, cfg_wait, cfg_max_power;
    int cfg_gp, cfg_gi, cfg_gd, cfg_gdr;

    // controller state
    longint integ_acc, last_err;
    int     settle_acc;
    bit     locked, move_finished;

    t_out_item expected_cmds[$];
    int        mismatches = 0;

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // power and drift are both Q.8
    function automatic logic signed [MOTOR_W-1:0] sat_motor(longint pw, longint dr);
        longint v;
        v = clamp_sym((pw + dr) / 256, MOTOR_LIMIT);
        return v[MOTOR_W-1:0];
    endfunction

    function automatic string fmt_cmd(t_out_item c);
        return $sformatf("fl=%0d fr=%0d bl=%0d br=%0d done=%0b", c.motor_front_left,
                         c.motor_front_right, c.motor_back_left, c.motor_back_right,
                         c.move_done);
    endfunction

    function automatic t_out_item control_tick(t_in_item it);
        t_out_item r;
        longint fl, fr, bl, br, gy, tgt, pos, err, integ, sum, pw, dr;
        int wait_eff;
        r = '0;
        fl = longint'(it.enc_front_left);
        fr = longint'(it.enc_front_right);
        bl = longint'(it.enc_back_left);
        br = longint'(it.enc_back_right);
        gy = longint'(it.gyro_tenths);
        tgt = cfg_target;
        wait_eff = (cfg_wait < MIN_WAIT_MS) ? MIN_WAIT_MS : cfg_wait;

        if (it.start_move) begin
            integ_acc = 0;
            last_err = 0;
            settle_acc = 0;
            locked = 1'b1;
            move_finished = 1'b0;
        end else if (!move_finished) begin
            settle_acc += TICK_MS;
            if (settle_acc > (1 << SETTLE_W) - 1) settle_acc = (1 << SETTLE_W) - 1;
        end

        // done state is sticky; unused direction codes finish at once
        if (move_finished || cfg_mode > MODE_WEST) begin
            move_finished = 1'b1;
            r.move_done = 1'b1;
            return r;
        end

        pos = (mag(fl) + mag(bl) + mag(fr) + mag(br)) / 4;
        if (cfg_mode <= MODE_SOUTH)
            err = (tgt * DRIVE_SCALE) / 16 - pos;
        else if (cfg_mode <= MODE_RIGHT)
            err = (mag(tgt) * TURN_SCALE) / 16 - mag(gy);
        else
            err = (tgt * STRAFE_SCALE) / 16 - pos;

        if (err != 0 && mag(err) < INTEGRAL_ZONE)
            integ = clamp_sym(integ_acc + err, INTEGRAL_LIMIT);
        else
            integ = 0;
        integ_acc = integ;

        sum = cfg_gp * err + cfg_gi * integ;
        if (err != 0) sum += cfg_gd * (err - last_err);
        last_err = err;

        pw = clamp_sym(sum / 256, cfg_max_power) * 256;
        dr = (cfg_mode == MODE_LEFT || cfg_mode == MODE_RIGHT) ? 0 : cfg_gdr * gy;

        if (err < UNLOCK_ERROR) locked = 1'b0;
        if (locked) settle_acc = 0;
        if (settle_acc >= wait_eff) begin
            move_finished = 1'b1;
            r.move_done = 1'b1;
            return r;
        end

        case (cfg_mode)
            MODE_NORTH: begin
                r.motor_front_left  = sat_motor(pw, -dr);
                r.motor_back_left   = r.motor_front_left;
                r.motor_front_right = sat_motor(pw, dr);
                r.motor_back_right  = r.motor_front_right;
            end
            MODE_SOUTH: begin
                r.motor_front_left  = sat_motor(-pw, -dr);
                r.motor_back_left   = r.motor_front_left;
                r.motor_front_right = sat_motor(-pw, dr);
                r.motor_back_right  = r.motor_front_right;
            end
            MODE_LEFT: begin
                r.motor_front_left  = sat_motor(-pw, 0);
                r.motor_back_left   = r.motor_front_left;
                r.motor_front_right = sat_motor(pw, 0);
                r.motor_back_right  = r.motor_front_right;
            end
            MODE_RIGHT: begin
                r.motor_front_left  = sat_motor(pw, 0);
                r.motor_back_left   = r.motor_front_left;
                r.motor_front_right = sat_motor(-pw, 0);
                r.motor_back_right  = r.motor_front_right;
            end
            MODE_EAST: begin
                r.motor_front_left  = sat_motor(pw, -dr);
                r.motor_front_right = sat_motor(-pw, dr);
                r.motor_back_left   = sat_motor(-pw, -dr);
                r.motor_back_right  = sat_motor(pw, dr);
            end
            default: begin
                r.motor_front_left  = sat_motor(-pw, -dr);
                r.motor_front_right = sat_motor(pw, dr);
                r.motor_back_left   = sat_motor(pw, -dr);
                r.motor_back_right  = sat_motor(-pw, dr);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_mode = MODE_NORTH;
            cfg_target = 0;
            cfg_wait = 250;
            cfg_max_power = 127;
            cfg_gp = 51;
            cfg_gi = 26;
            cfg_gd = 102;
            cfg_gdr = 205;
            integ_acc = 0;
            last_err = 0;
            settle_acc = 0;
            locked = 1'b1;
            move_finished = 1'b0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DIRECTION: cfg_mode = i_cfg_data[2:0];
                    REG_TARGET:    cfg_target = int'($signed(i_cfg_data));
                    REG_WAIT:      cfg_wait = i_cfg_data;
                    REG_MAX_POWER: cfg_max_power = i_cfg_data[6:0];
                    REG_GAIN_P:    cfg_gp = i_cfg_data[7:0];
                    REG_GAIN_I:    cfg_gi = i_cfg_data[7:0];
                    REG_GAIN_D:    cfg_gd = i_cfg_data[7:0];
                    REG_GAIN_DR:   cfg_gdr = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_cmds.push_back(control_tick(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result with no request pending: %s",
                                 fmt_cmd(i_out_item));
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_out_item !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR: motor command mismatch at %0t: exp %s got %s",
                                     $realtime, fmt_cmd(want), fmt_cmd(i_out_item));
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_cmds.size();
    end

endmodule

// ===== verif/drive_pid_with_drift_correction_tb.sv =====
// Testbench top for drive_pid_with_drift_correction: clock, reset, register setup and
// move stimulus with random idling. Depends on dpd_pkg, the block and dpd_motor_checker.
module drive_pid_with_drift_correction_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpd_pkg::*;

    localparam int TICKS_TARGET   = 850;
    localparam int HOLD_LEN       = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_DIR_CODES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int ticks_sent = 0;
    int n_errors;
    int n_pending;

    always #4 clk = ~clk;

    drive_pid_with_drift_correction i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dpd_motor_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(255);
    endfunction

    // encoder reading of one wheel with a random direction sign
    function automatic int wheel(int lvl);
        int v;
        v = lvl + jitter(3);
        return $urandom_range(1) ? v : -v;
    endfunction

    task automatic send_tick(bit start, int fl, int fr, int bl, int br, int gyro);
        t_in_item it;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.start_move      = start;
        it.enc_front_left  = fl[ENC_W-1:0];
        it.enc_front_right = fr[ENC_W-1:0];
        it.enc_back_left   = bl[ENC_W-1:0];
        it.enc_back_right  = br[ENC_W-1:0];
        it.gyro_tenths     = gyro[GYRO_W-1:0];
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // stop offering requests and wait until every result has come back
    task automatic wait_idle(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic program_regs(int mode, int target, int wait_v, int maxp,
                                int gp, int gi, int gd, int gdr);
        logic [15:0] vals [NUM_DIR_CODES];
        vals[REG_DIRECTION] = mode[15:0];
        vals[REG_TARGET]    = target[15:0];
        vals[REG_WAIT]      = wait_v[15:0];
        vals[REG_MAX_POWER] = maxp[15:0];
        vals[REG_GAIN_P]    = gp[15:0];
        vals[REG_GAIN_I]    = gi[15:0];
        vals[REG_GAIN_D]    = gd[15:0];
        vals[REG_GAIN_DR]   = gdr[15:0];
        for (int k = 0; k < NUM_DIR_CODES; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= k[2:0];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // One move: ramp toward the target, then hover near it.
    task automatic random_move(bit hold_off, bit pause_mid);
        int  r, mode, tgt, wait_v, maxp, goal, ramp, n_ticks, pause_at, lvl, gy, wait_eff;
        bit  clean_start, start;
        r = $urandom_range(99);
        mode = (r < 5) ? MODE_WEST + 1 + $urandom_range(1) : $urandom_range(MODE_WEST);
        if ($urandom_range(9) == 0)
            tgt = int'(shortint'($urandom));
        else
            tgt = int'($urandom_range(800)) - 400;
        r = $urandom_range(99);
        if (r < 55)
            wait_v = $urandom_range(MIN_WAIT_MS - 1);
        else if (r < 92)
            wait_v = MIN_WAIT_MS + $urandom_range(250);
        else
            wait_v = $urandom_range(16'hFFFF);
        r = $urandom_range(99);
        maxp = (r < 10) ? 0 : (r < 25) ? MOTOR_LIMIT : $urandom_range(MOTOR_LIMIT);

        if (mode <= MODE_SOUTH)
            goal = (tgt * DRIVE_SCALE) / 16;
        else if (mode <= MODE_RIGHT)
            goal = ((tgt < 0 ? -tgt : tgt) * TURN_SCALE) / 16;
        else
            goal = (tgt * STRAFE_SCALE) / 16;
        wait_eff = (wait_v < MIN_WAIT_MS) ? MIN_WAIT_MS : wait_v;
        ramp = $urandom_range(8, 2);
        n_ticks = ramp + ((wait_eff / TICK_MS > 30) ? 30 : wait_eff / TICK_MS)
                  + $urandom_range(6);
        pause_at = pause_mid ? $urandom_range(n_ticks - 1, 1) : -1;
        clean_start = ($urandom_range(9) != 0);

        wait_idle(DRAIN_CYCLES);
        program_regs(mode, tgt, wait_v, maxp, pick_gain(), pick_gain(), pick_gain(),
                     pick_gain());
        if (hold_off) hold_req <= ~hold_req;

        for (int k = 0; k < n_ticks; k++) begin
            if (k == pause_at) wait_idle(0);
            start = (k == 0 && clean_start) || ($urandom_range(99) < 2);
            lvl = ((k >= ramp) ? goal : (goal * k) / ramp) + jitter(60);
            if ($urandom_range(99) < 8) begin
                send_tick(start, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (mode == MODE_LEFT || mode == MODE_RIGHT) begin
                gy = $urandom_range(1) ? lvl : -lvl;
                send_tick(start, jitter(1000), jitter(1000), jitter(1000), jitter(1000), gy);
            end else begin
                gy = ($urandom_range(19) == 0) ? int'(shortint'($urandom)) : jitter(300);
                send_tick(start, wheel(lvl), wheel(lvl), wheel(lvl), wheel(lvl), gy);
            end
        end
    endtask

    initial begin
        int move_no;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, zero error, small error inside the integral zone
        program_regs(MODE_NORTH, 800, 0, MOTOR_LIMIT, 255, 255, 255, 255);
        send_tick(1'b1, 0, 0, 0, 0, 32767);
        send_tick(1'b0, 8388607, 8388607, 8388607, 8388607, -32768);
        send_tick(1'b0, -8388608, -8388608, -8388608, -8388608, 0);
        send_tick(1'b0, 3500, -3500, 3500, -3500, 100);
        send_tick(1'b0, 3495, 3495, -3495, 3495, -100);
        send_tick(1'b0, 3300, 3300, 3300, 3300, 7);

        // every direction code but north, unused ones included
        for (int m = MODE_SOUTH; m < NUM_DIR_CODES; m++) begin
            wait_idle(DRAIN_CYCLES);
            program_regs(m, m[0] ? -1200 : 1200, MIN_WAIT_MS, 100, 51, 26, 102, 205);
            send_tick(1'b1, 0, 0, 0, 0, 500);
            send_tick(1'b0, 4000, -5000, 3000, -2000, -500);
        end

        wait_idle(DRAIN_CYCLES);
        program_regs(MODE_WEST, -32768, 16'hFFFF, 0, 0, 0, 0, 0);
        send_tick(1'b1, 1000, 1000, -1000, -1000, 32767);
        send_tick(1'b0, -8388608, 8388607, 0, 5, -32768);

        move_no = 0;
        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct   = (phase == 0) ? 29 : (phase == 1) ? 53 : 0;
            out_idle_pct <= (phase == 0) ? 53 : (phase == 1) ? 29 : 0;
            for (int first = 1; ticks_sent < TICKS_TARGET * (phase + 1) / 3; first = 0) begin
                random_move(first != 0 && phase != 1, (move_no % 4) == 1);
                move_no++;
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (n_errors == 0 && n_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
